>>> hdl/gclp_pkg.sv
// ============================================================================
// G-code line parser package
// Shared types, character codes and constants for the line parser.
// ============================================================================
package gclp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int M_DATA_W        = 184;

    localparam logic [15:0] G_NONE = 16'd256;
    localparam logic [15:0] G_MAX  = 16'd255;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_Z     = 8'h7A;

    typedef enum logic [2:0] {
        FL_NONE,
        FL_G,
        FL_N,
        FL_X,
        FL_Y,
        FL_Z,
        FL_CS
    } field_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic [31:0]       line_count;
        logic [7:0]        xor_accum;
        field_t            field_letter;
        phase_t            number_phase;
        logic              number_negative;
        logic              in_fraction;
        logic [1:0]        fraction_digits;
        logic [4:0]        field_flags;
        logic              error_flag;
        logic              scan_stopped;
        logic [15:0]       g_value;
        logic [31:0]       n_value;
        logic [2:0][31:0]  coord_values;
        logic [7:0]        checksum_given;
        logic [7:0]        checksum_computed;
    } line_state_t;

    typedef struct packed {
        logic [31:0] line_counter;
        logic [31:0] z_value;
        logic        has_z;
        logic [31:0] y_value;
        logic        has_y;
        logic [31:0] x_value;
        logic        has_x;
        logic [31:0] line_number;
        logic        has_n;
        logic [15:0] g_code;
        logic        accepted;
    } result_t;

    function automatic logic [9:0] frac_scale(input logic [1:0] fd);
        logic [9:0] s;
        case (fd)
            2'd0:    s = 10'd100;
            2'd1:    s = 10'd10;
            2'd2:    s = 10'd1;
            default: s = 10'd0;
        endcase
        return s;
    endfunction

    function automatic line_state_t line_clear(input logic [31:0] line_count);
        line_state_t s;
        s                   = '0;
        s.line_count        = line_count;
        s.field_letter      = FL_NONE;
        s.number_phase      = PH_IDLE;
        s.g_value           = G_NONE;
        return s;
    endfunction

endpackage

>>> hdl/gclp_step.sv
// ============================================================================
// G-code line parser character step
// Next line state for one character, and the result at end of line.
// ============================================================================
module gclp_step import gclp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                          op,
    input  logic [7:0]                                    ch,
    input  logic                                          end_of_line,
    input  line_state_t                                   st,
    input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32):0] acc,
    output line_state_t                                   st_next,
    output logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32):0] acc_next,
    output logic                                          res_valid,
    output result_t                                       res
);

    localparam int ACC_W = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
    localparam int SUM_W = ACC_W + 4;
    localparam logic [SUM_W-1:0] CAP_INT = SUM_W'(1) << 32;
    localparam logic [SUM_W-1:0] CAP_DEC = SUM_W'(1) << COORD_WIDTH;
    localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (COORD_WIDTH - 1);

    function automatic logic [ACC_W-1:0] add_digit(
        input logic [ACC_W-1:0] a,
        input logic             dec,
        input logic             frac,
        input logic [1:0]       fd,
        input logic [3:0]       d
    );
        logic [SUM_W-1:0] x10;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] cap;
        logic [13:0]      d1000;
        x10   = (SUM_W'(a) << 3) + (SUM_W'(a) << 1);
        d1000 = 14'(d) * 14'd1000;
        cap   = dec ? CAP_DEC : CAP_INT;
        if (!dec)
        begin
            sum = x10 + SUM_W'(d);
        end
        else if (!frac)
        begin
            sum = x10 + SUM_W'(d1000);
        end
        else if (fd != 2'd3)
        begin
            sum = SUM_W'(a) + SUM_W'(10'(d) * frac_scale(fd));
        end
        else
        begin
            sum = SUM_W'(a);
        end
        return (sum > cap) ? cap[ACC_W-1:0] : sum[ACC_W-1:0];
    endfunction

    function automatic logic [31:0] long_val(input logic [ACC_W-1:0] a, input logic neg);
        logic [31:0] v;
        if (!neg)
        begin
            v = (a > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : a[31:0];
        end
        else
        begin
            v = (a > ACC_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'd0 - a[31:0];
        end
        return v;
    endfunction

    function automatic logic [31:0] coord_val(input logic [ACC_W-1:0] a, input logic neg);
        logic [ACC_W-1:0] v;
        if (!neg)
        begin
            v = (a > HALF - ACC_W'(1)) ? HALF - ACC_W'(1) : a;
        end
        else
        begin
            v = (a > HALF) ? ACC_W'(0) - HALF : ACC_W'(0) - a;
        end
        return v[31:0];
    endfunction

    function automatic line_state_t commit_num(input line_state_t si, input logic [ACC_W-1:0] a);
        line_state_t so;
        logic [31:0] lv;
        logic [31:0] cv;
        so = si;
        lv = long_val(a, si.number_negative);
        cv = coord_val(a, si.number_negative);
        case (si.field_letter)
            FL_G:
            begin
                so.g_value        = lv[15:0];
                so.field_flags[0] = 1'b1;
                if (lv[15:0] > G_MAX)
                begin
                    so.error_flag = 1'b1;
                end
            end
            FL_N:
            begin
                so.n_value        = lv;
                so.field_flags[1] = 1'b1;
                if (si.line_count + 32'd1 == lv || si.line_count == lv)
                begin
                    so.line_count = lv;
                end
                else
                begin
                    so.error_flag = 1'b1;
                end
            end
            FL_X:
            begin
                so.coord_values[0] = cv;
                so.field_flags[2]  = 1'b1;
            end
            FL_Y:
            begin
                so.coord_values[1] = cv;
                so.field_flags[3]  = 1'b1;
            end
            FL_Z:
            begin
                so.coord_values[2] = cv;
                so.field_flags[4]  = 1'b1;
            end
            FL_CS:
            begin
                so.checksum_given = lv[7:0];
                if (lv[7:0] != si.checksum_computed)
                begin
                    so.error_flag = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        so.field_letter = FL_NONE;
        so.number_phase = PH_IDLE;
        if (so.error_flag)
        begin
            so.scan_stopped = 1'b1;
        end
        return so;
    endfunction

    line_state_t      s;
    logic [ACC_W-1:0] a;
    logic             is_digit;
    logic             is_blank;
    logic             is_dec;
    logic             is_end;
    logic             cont;
    logic             skip;
    logic [7:0]       lower;
    logic [3:0]       d;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
    assign is_dec   = (st.field_letter == FL_X) || (st.field_letter == FL_Y)
                   || (st.field_letter == FL_Z);
    assign is_end   = (ch == CH_NUL) || (ch == CH_LPAR) || (ch == CH_PCT) || (ch == CH_SEMI)
                   || (ch == CH_LF) || (ch == CH_CR);
    assign lower    = ch | CH_CASE;
    assign d        = ch[3:0];

    always_comb
    begin
        s         = st;
        a         = acc;
        cont      = 1'b0;
        skip      = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        if (op)
        begin
            s.line_count = '0;
        end
        else
        begin
            if (!s.scan_stopped)
            begin
                if (s.number_phase != PH_IDLE)
                begin
                    if (s.number_phase == PH_LEAD && is_blank)
                    begin
                        cont = 1'b1;
                    end
                    else if (s.number_phase == PH_LEAD && (ch == CH_PLUS || ch == CH_MINUS))
                    begin
                        cont              = 1'b1;
                        s.number_negative = (ch == CH_MINUS);
                        s.number_phase    = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        cont           = 1'b1;
                        s.number_phase = PH_DIGITS;
                        a = add_digit(acc, is_dec, st.in_fraction, st.fraction_digits, d);
                        if (is_dec && st.in_fraction && st.fraction_digits != 2'd3)
                        begin
                            s.fraction_digits = st.fraction_digits + 2'd1;
                        end
                    end
                    else if (is_dec && ch == CH_DOT && !st.in_fraction)
                    begin
                        cont           = 1'b1;
                        s.number_phase = PH_DIGITS;
                        s.in_fraction  = 1'b1;
                    end
                    if (cont)
                    begin
                        s.xor_accum = st.xor_accum ^ ch;
                        skip        = 1'b1;
                    end
                    else
                    begin
                        s    = commit_num(s, acc);
                        skip = s.scan_stopped;
                    end
                end
                if (!skip)
                begin
                    if (is_end)
                    begin
                        s.scan_stopped = 1'b1;
                    end
                    else if (ch == CH_STAR)
                    begin
                        if (!s.field_flags[1])
                        begin
                            s.error_flag   = 1'b1;
                            s.scan_stopped = 1'b1;
                        end
                        else
                        begin
                            s.checksum_computed = s.xor_accum;
                            s.xor_accum         = CH_STAR;
                            s.field_letter      = FL_CS;
                        end
                    end
                    else
                    begin
                        s.xor_accum = s.xor_accum ^ ch;
                        case (lower)
                            CH_G:    s.field_letter = FL_G;
                            CH_N:    s.field_letter = FL_N;
                            CH_X:    s.field_letter = FL_X;
                            CH_Y:    s.field_letter = FL_Y;
                            CH_Z:    s.field_letter = FL_Z;
                            default: s.field_letter = FL_NONE;
                        endcase
                    end
                    if (s.field_letter != FL_NONE)
                    begin
                        s.number_phase    = PH_LEAD;
                        s.number_negative = 1'b0;
                        s.in_fraction     = 1'b0;
                        s.fraction_digits = 2'd0;
                        a                 = '0;
                    end
                end
            end
            if (end_of_line)
            begin
                if (!s.scan_stopped && s.number_phase != PH_IDLE)
                begin
                    s = commit_num(s, a);
                end
                if (s.field_flags[1] && s.checksum_given == 8'd0)
                begin
                    s.error_flag = 1'b1;
                end
                res_valid        = 1'b1;
                res.accepted     = !s.error_flag && s.field_flags[0] && (s.g_value <= G_MAX);
                res.g_code       = s.g_value;
                res.has_n        = s.field_flags[1];
                res.line_number  = s.n_value;
                res.has_x        = s.field_flags[2];
                res.x_value      = s.coord_values[0];
                res.has_y        = s.field_flags[3];
                res.y_value      = s.coord_values[1];
                res.has_z        = s.field_flags[4];
                res.z_value      = s.coord_values[2];
                res.line_counter = s.line_count;
                s                = line_clear(s.line_count);
                a                = '0;
            end
        end
        st_next  = s;
        acc_next = a;
    end

endmodule

>>> hdl/gcode_line_parser_core.sv
// ============================================================================
// G-code line parser core
// Parses G, N, X, Y, Z and XOR checksum fields of G-code lines, one
// character per cycle while s_tready is high, and gives one result per line.
// ============================================================================
// Input channel (s_*): one item per character. s_tdata carries the character,
// s_tlast marks the final character of a line, s_tuser set to one clears the
// line counter instead (character and tlast are then ignored).
// Output channel (m_*): one item per line, the parsed fields, the accepted
// flag and the line counter as it stands after the line.
// Throughput: one character per cycle; the parse of a character, including
// the multiply by ten of the number accumulator and the final field commit,
// sits between the line state register and the result register.
// Result: m_tvalid rises in the cycle after the last character of its line is accepted.
// Reset: line counter zero, per-line state cleared, no result pending.
// Stall: the result register holds while m_tready is low; s_tready drops only
// while a result waits and m_tready is low, and rises again the cycle the
// result is taken.
// ============================================================================
module gcode_line_parser_core import gclp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // ch
    input  logic                 s_tuser,   // op
    input  logic                 s_tlast,   // end_of_line
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata    // accepted, g_code, has_n, line_number,
                                            // has_x, x_value, has_y, y_value,
                                            // has_z, z_value, line_counter, zero pad
);

    localparam int ACC_W = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;

    line_state_t          st_reg;
    line_state_t          st_next;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic                 res_valid;
    result_t              res;
    logic                 s_fire;

    gclp_step #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .op          (s_tuser),
        .ch          (s_tdata),
        .end_of_line (s_tlast),
        .st          (st_reg),
        .acc         (acc_reg),
        .st_next     (st_next),
        .acc_next    (acc_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (s_fire && res_valid)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= line_clear(32'd0);
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                st_reg  <= st_next;
                acc_reg <= acc_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && res_valid)
        begin
            m_tdata_reg <= M_DATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/gclp_checker.sv
// ============================================================================
// G-code line parser port checker
// Concurrent checks on the parser's ports, bound to the top level.
// ============================================================================
module gclp_checker import gclp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata
);

    logic eol_fire;

    assign eol_fire = s_tvalid && s_tready && s_tlast && !s_tuser && (s_tdata == s_tdata);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_line_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        eol_fire |=> m_tvalid)
        else $error("no result after end of line");

    a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked without a stalled result");

    a_accepted_g_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[16:9] == 8'd0)
        else $error("accepted line with G above 255");

    a_x_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[50] |-> m_tdata[82:51] == 32'd0)
        else $error("X value without X field");

endmodule

bind gcode_line_parser_core gclp_checker u_gclp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
